>>> src/eight_zone_line_rasterizer_defines.svh
// Assertion macros for the line rasterizer top level.
`ifndef EIGHT_ZONE_LINE_RASTERIZER_DEFINES_SVH
`define EIGHT_ZONE_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EZLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EZLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer next-cycle check failed");

`endif

>>> src/ezlr_pkg.sv
`timescale 1ns / 1ps

package ezlr_pkg;

    // Default coordinate width in screen space.
    localparam int COORD_BITS_DEF = 12;

    // Command codes carried on the slave-side tuser.
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_NEXT  = 1'b1
    } cmd_t;

    // Zone (octant) of a line; zone 0 has 0 <= dy <= dx.
    typedef enum logic [2:0] {
        ZONE_0 = 3'd0,
        ZONE_1 = 3'd1,
        ZONE_2 = 3'd2,
        ZONE_3 = 3'd3,
        ZONE_4 = 3'd4,
        ZONE_5 = 3'd5,
        ZONE_6 = 3'd6,
        ZONE_7 = 3'd7
    } zone_t;

    // Status of the pixel produced for one command.
    typedef struct packed {
        logic valid;
        logic last;
    } pix_flags_t;

endpackage

>>> src/ezlr_setup.sv
`timescale 1ns / 1ps

// Line setup: picks the zone, maps both endpoints into zone 0 and derives
// the midpoint step values and the initial decision variable.
module ezlr_setup #(
    parameter int COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output ezlr_pkg::zone_t              zone,
    output logic signed [COORD_BITS:0]   first_x,
    output logic signed [COORD_BITS:0]   first_y,
    output logic signed [COORD_BITS:0]   stop_x,
    output logic signed [COORD_BITS+1:0] step_east,
    output logic signed [COORD_BITS+1:0] step_diag,
    output logic signed [COORD_BITS+2:0] decision
);
    import ezlr_pkg::*;

    localparam int W = COORD_BITS + 1;

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] xe;
    logic signed [W-1:0] ye;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic        [W-1:0] adx;
    logic        [W-1:0] ady;
    logic                x_major;
    logic signed [W-1:0] zx0;
    logic signed [W-1:0] zy0;
    logic signed [W-1:0] zx1;
    logic signed [W-1:0] zy1;
    logic signed [W-1:0] ddx;
    logic signed [W-1:0] ddy;
    logic signed [W-1:0] dyx;

    // Forward zone transform, x component.
    function automatic logic signed [W-1:0] map_x(zone_t z, logic signed [W-1:0] x,
                                                  logic signed [W-1:0] y);
        logic signed [W-1:0] r;
        case (z)
            ZONE_0:  r = x;
            ZONE_1:  r = y;
            ZONE_2:  r = y;
            ZONE_3:  r = -x;
            ZONE_4:  r = -x;
            ZONE_5:  r = -y;
            ZONE_6:  r = -y;
            default: r = x;
        endcase
        return r;
    endfunction

    // Forward zone transform, y component.
    function automatic logic signed [W-1:0] map_y(zone_t z, logic signed [W-1:0] x,
                                                  logic signed [W-1:0] y);
        logic signed [W-1:0] r;
        case (z)
            ZONE_0:  r = y;
            ZONE_1:  r = x;
            ZONE_2:  r = -x;
            ZONE_3:  r = y;
            ZONE_4:  r = -y;
            ZONE_5:  r = -x;
            ZONE_6:  r = x;
            default: r = -y;
        endcase
        return r;
    endfunction

    // Sign-extend the endpoints so differences and negations cannot wrap.
    assign xs = {x_start[COORD_BITS-1], x_start};
    assign ys = {y_start[COORD_BITS-1], y_start};
    assign xe = {x_end[COORD_BITS-1], x_end};
    assign ye = {y_end[COORD_BITS-1], y_end};

    assign dx  = xe - xs;
    assign dy  = ye - ys;
    assign adx = dx[W-1] ? W'(-dx) : W'(dx);
    assign ady = dy[W-1] ? W'(-dy) : W'(dy);
    assign x_major = (adx >= ady);

    // Zone choice from the major axis and the signs of dx and dy.
    always_comb
    begin
        case ({x_major, dx[W-1], dy[W-1]})
            3'b100:  zone = ZONE_0;
            3'b101:  zone = ZONE_7;
            3'b110:  zone = ZONE_3;
            3'b111:  zone = ZONE_4;
            3'b000:  zone = ZONE_1;
            3'b001:  zone = ZONE_6;
            3'b010:  zone = ZONE_2;
            default: zone = ZONE_5;
        endcase
    end

    // Endpoints in zone-0 coordinates.
    assign zx0 = map_x(zone, xs, ys);
    assign zy0 = map_y(zone, xs, ys);
    assign zx1 = map_x(zone, xe, ye);
    assign zy1 = map_y(zone, xe, ye);

    // Differences in zone 0 lie in 0..2^COORD_BITS-1 and fit W bits.
    assign ddx = zx1 - zx0;
    assign ddy = zy1 - zy0;
    assign dyx = ddy - ddx;

    assign first_x   = zx0;
    assign first_y   = zy0;
    assign stop_x    = zx1;
    assign step_east = {ddy, 1'b0};
    assign step_diag = {dyx, 1'b0};
    assign decision  = $signed({ddy[W-1], ddy, 1'b0}) - $signed({{2{ddx[W-1]}}, ddx});

endmodule

>>> src/ezlr_core.sv
`timescale 1ns / 1ps

// Line state and midpoint stepper. On a start it loads the setup values and
// presents the first point; on a next while a line is active it makes one
// step of the decision variable. State moves only on a fire cycle.
module ezlr_core #(
    parameter int COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  ezlr_pkg::cmd_t               cmd,
    input  ezlr_pkg::zone_t              set_zone,
    input  logic signed [COORD_BITS:0]   set_first_x,
    input  logic signed [COORD_BITS:0]   set_first_y,
    input  logic signed [COORD_BITS:0]   set_stop_x,
    input  logic signed [COORD_BITS+1:0] set_step_east,
    input  logic signed [COORD_BITS+1:0] set_step_diag,
    input  logic signed [COORD_BITS+2:0] set_decision,
    output ezlr_pkg::zone_t              pix_zone,
    output logic signed [COORD_BITS:0]   pix_x,
    output logic signed [COORD_BITS:0]   pix_y,
    output ezlr_pkg::pix_flags_t         pix_flags
);
    import ezlr_pkg::*;

    localparam int W = COORD_BITS + 1;

    logic signed [W-1:0] cur_x_reg;
    logic signed [W-1:0] cur_x_next;
    logic signed [W-1:0] cur_y_reg;
    logic signed [W-1:0] cur_y_next;
    logic signed [W-1:0] stop_x_reg;
    logic signed [W-1:0] stop_x_next;
    logic signed [W+1:0] decision_reg;
    logic signed [W+1:0] decision_next;
    logic signed [W:0]   step_east_reg;
    logic signed [W:0]   step_east_next;
    logic signed [W:0]   step_diag_reg;
    logic signed [W:0]   step_diag_next;
    zone_t               zone_reg;
    zone_t               zone_next;
    logic                active_reg;
    logic                active_next;

    logic                dec_neg;
    logic signed [W+1:0] dec_stepped;
    logic signed [W-1:0] step_x;
    logic signed [W-1:0] step_y;
    logic                step_last;
    logic                start_last;

    // One midpoint step from the current point.
    assign dec_neg     = decision_reg[W+1];
    assign dec_stepped = dec_neg ? decision_reg + {step_east_reg[W], step_east_reg}
                                 : decision_reg + {step_diag_reg[W], step_diag_reg};
    assign step_x      = cur_x_reg + W'(1);
    assign step_y      = dec_neg ? cur_y_reg : cur_y_reg + W'(1);
    assign step_last   = (step_x >= stop_x_reg);
    assign start_last  = (set_first_x >= set_stop_x);

    // Next state and the point presented for this command.
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        stop_x_next    = stop_x_reg;
        decision_next  = decision_reg;
        step_east_next = step_east_reg;
        step_diag_next = step_diag_reg;
        zone_next      = zone_reg;
        active_next    = active_reg;
        pix_zone       = zone_reg;
        pix_x          = step_x;
        pix_y          = step_y;
        pix_flags      = '{valid: 1'b0, last: 1'b0};
        case (cmd)
            CMD_START:
            begin
                cur_x_next     = set_first_x;
                cur_y_next     = set_first_y;
                stop_x_next    = set_stop_x;
                decision_next  = set_decision;
                step_east_next = set_step_east;
                step_diag_next = set_step_diag;
                zone_next      = set_zone;
                active_next    = !start_last;
                pix_zone       = set_zone;
                pix_x          = set_first_x;
                pix_y          = set_first_y;
                pix_flags      = '{valid: 1'b1, last: start_last};
            end
            CMD_NEXT:
            begin
                if (active_reg)
                begin
                    cur_x_next    = step_x;
                    cur_y_next    = step_y;
                    decision_next = dec_stepped;
                    active_next   = !step_last;
                    pix_flags     = '{valid: 1'b1, last: step_last};
                end
            end
            default:
            begin
                pix_flags = '{valid: 1'b0, last: 1'b0};
            end
        endcase
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            stop_x_reg    <= '0;
            decision_reg  <= '0;
            step_east_reg <= '0;
            step_diag_reg <= '0;
            zone_reg      <= ZONE_0;
            active_reg    <= 1'b0;
        end
        else if (fire)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            stop_x_reg    <= stop_x_next;
            decision_reg  <= decision_next;
            step_east_reg <= step_east_next;
            step_diag_reg <= step_diag_next;
            zone_reg      <= zone_next;
            active_reg    <= active_next;
        end
    end

endmodule

>>> src/ezlr_unmap.sv
`timescale 1ns / 1ps

// Inverse zone transform: takes a zone-0 point back to screen coordinates.
module ezlr_unmap #(
    parameter int COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
    input  ezlr_pkg::zone_t              zone,
    input  logic signed [COORD_BITS:0]   zx,
    input  logic signed [COORD_BITS:0]   zy,
    output logic signed [COORD_BITS-1:0] sx,
    output logic signed [COORD_BITS-1:0] sy
);
    import ezlr_pkg::*;

    logic signed [COORD_BITS:0] wx;
    logic signed [COORD_BITS:0] wy;

    always_comb
    begin
        case (zone)
            ZONE_0:
            begin
                wx = zx;
                wy = zy;
            end
            ZONE_1:
            begin
                wx = zy;
                wy = zx;
            end
            ZONE_2:
            begin
                wx = -zy;
                wy = zx;
            end
            ZONE_3:
            begin
                wx = -zx;
                wy = zy;
            end
            ZONE_4:
            begin
                wx = -zx;
                wy = -zy;
            end
            ZONE_5:
            begin
                wx = -zy;
                wy = -zx;
            end
            ZONE_6:
            begin
                wx = zy;
                wy = -zx;
            end
            default:
            begin
                wx = zx;
                wy = -zy;
            end
        endcase
    end

    // Points on the segment always fit the screen width.
    assign sx = wx[COORD_BITS-1:0];
    assign sy = wy[COORD_BITS-1:0];

endmodule

>>> src/eight_zone_line_rasterizer.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat contents (low bits first)
// s_*      in   tdata: x_start, y_start, x_end, y_end; tuser: cmd
// m_*      out  tdata: pixel_x, pixel_y; tuser: pixel_valid; tlast: last_pixel
//
// Every command beat yields exactly one pixel beat, held first in the input
// register and then in the result register, at one beat per clock while the
// output does not stall, a rate set by the combinational setup and midpoint
// step between the two registers. A stalled result holds in the result register
// while one more command waits in the input register; the line state advances
// only when a command moves on. Reset idles the line state and empties both registers.
module eight_zone_line_rasterizer #(
    parameter int COORD_BITS = ezlr_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // x_start, y_start, x_end, y_end
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // cmd
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    // pixel_valid
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import ezlr_pkg::*;

    `include "eight_zone_line_rasterizer_defines.svh"

    localparam int C          = COORD_BITS;
    localparam int OUT_DATA_W = ((2*C+7)/8)*8;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    cmd_t                  in_cmd_reg;
    logic signed [C-1:0]   in_xs_reg;
    logic signed [C-1:0]   in_ys_reg;
    logic signed [C-1:0]   in_xe_reg;
    logic signed [C-1:0]   in_ye_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_pv_reg;
    logic                  out_last_reg;

    logic                  advance;
    logic                  in_take;
    zone_t                 set_zone;
    logic signed [C:0]     set_first_x;
    logic signed [C:0]     set_first_y;
    logic signed [C:0]     set_stop_x;
    logic signed [C+1:0]   set_step_east;
    logic signed [C+1:0]   set_step_diag;
    logic signed [C+2:0]   set_decision;
    zone_t                 pix_zone;
    logic signed [C:0]     pix_zx;
    logic signed [C:0]     pix_zy;
    pix_flags_t            pix_flags;
    logic signed [C-1:0]   pix_sx;
    logic signed [C-1:0]   pix_sy;
    logic [OUT_DATA_W-1:0] out_data_next;

    // Handshake: the command in the input register moves on whenever the
    // result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Valid flags of both registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_xs_reg  <= s_tdata[C-1:0];
            in_ys_reg  <= s_tdata[2*C-1:C];
            in_xe_reg  <= s_tdata[3*C-1:2*C];
            in_ye_reg  <= s_tdata[4*C-1:3*C];
        end
    end

    ezlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start   (in_xs_reg),
        .y_start   (in_ys_reg),
        .x_end     (in_xe_reg),
        .y_end     (in_ye_reg),
        .zone      (set_zone),
        .first_x   (set_first_x),
        .first_y   (set_first_y),
        .stop_x    (set_stop_x),
        .step_east (set_step_east),
        .step_diag (set_step_diag),
        .decision  (set_decision)
    );

    ezlr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .cmd           (in_cmd_reg),
        .set_zone      (set_zone),
        .set_first_x   (set_first_x),
        .set_first_y   (set_first_y),
        .set_stop_x    (set_stop_x),
        .set_step_east (set_step_east),
        .set_step_diag (set_step_diag),
        .set_decision  (set_decision),
        .pix_zone      (pix_zone),
        .pix_x         (pix_zx),
        .pix_y         (pix_zy),
        .pix_flags     (pix_flags)
    );

    ezlr_unmap #(
        .COORD_BITS (COORD_BITS)
    ) u_unmap (
        .zone (pix_zone),
        .zx   (pix_zx),
        .zy   (pix_zy),
        .sx   (pix_sx),
        .sy   (pix_sy)
    );

    // A next command with no line gives an all-zero beat.
    assign out_data_next = pix_flags.valid ? OUT_DATA_W'({pix_sy, pix_sx}) : '0;

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_pv_reg   <= pix_flags.valid;
            out_last_reg <= pix_flags.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_pv_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the datapath and the register handoff.
    `EZLR_ASSERT_NOW(a_last_is_pixel, m_tvalid && m_tlast, m_tuser)
    `EZLR_ASSERT_NOW(a_idle_beat_zero, m_tvalid && !m_tuser, m_tdata == '0 && !m_tlast)
    `EZLR_ASSERT_NEXT(a_input_kept, in_valid_reg && !advance, in_valid_reg)

endmodule

>>> tb/eight_zone_line_rasterizer_tb.sv
`timescale 1ns / 1ps

module eight_zone_line_rasterizer_tb;

    import ezlr_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int CMAX      = (1 << (CW - 1)) - 1;
    localparam int CMIN      = -(1 << (CW - 1));
    localparam int MAX_CYCLE = 300000;
    localparam int DRAIN_CYC = 8;

    // One command beat as the driver presents it.
    typedef struct {
        cmd_t                  cmd;
        logic signed [CW-1:0]  xs;
        logic signed [CW-1:0]  ys;
        logic signed [CW-1:0]  xe;
        logic signed [CW-1:0]  ye;
    } line_cmd_t;

    // One pixel beat as the block should return it.
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          valid;
        logic          last;
    } pixel_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [((4*CW+7)/8)*8-1:0]    s_tdata = '0;
    logic                         s_tuser = CMD_START;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [((2*CW+7)/8)*8-1:0]    m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    line_cmd_t cmd_q[$];
    pixel_t    pixels_due_q[$];
    line_cmd_t cmd_on_bus;
    pixel_t    pixel_due;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        err_cnt = 0;
    int        cycle_cnt = 0;

    // Rasterizer state kept by the predictor, in zone-0 coordinates.
    logic signed [CW:0]   pos_x;
    logic signed [CW:0]   pos_y;
    logic signed [CW:0]   end_x;
    logic signed [CW+3:0] err_term;
    logic signed [CW+1:0] inc_east;
    logic signed [CW+1:0] inc_diag;
    zone_t                line_zone;
    bit                   drawing;

    eight_zone_line_rasterizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Map a screen point into zone 0.
    function automatic void fold_to_zone0(input zone_t z, input int x, input int y,
                                          output int fx, output int fy);
        case (z)
            ZONE_0: begin fx = x;  fy = y;  end
            ZONE_1: begin fx = y;  fy = x;  end
            ZONE_2: begin fx = y;  fy = -x; end
            ZONE_3: begin fx = -x; fy = y;  end
            ZONE_4: begin fx = -x; fy = -y; end
            ZONE_5: begin fx = -y; fy = -x; end
            ZONE_6: begin fx = -y; fy = x;  end
            default: begin fx = x; fy = -y; end
        endcase
    endfunction

    // Map a zone-0 point back to the screen.
    function automatic void unfold_from_zone0(input zone_t z, input int fx, input int fy,
                                              output int x, output int y);
        case (z)
            ZONE_0: begin x = fx;  y = fy;  end
            ZONE_1: begin x = fy;  y = fx;  end
            ZONE_2: begin x = -fy; y = fx;  end
            ZONE_3: begin x = -fx; y = fy;  end
            ZONE_4: begin x = -fx; y = -fy; end
            ZONE_5: begin x = -fy; y = -fx; end
            ZONE_6: begin x = fy;  y = -fx; end
            default: begin x = fx; y = -fy; end
        endcase
    endfunction

    // Advance the line state by one command and return the pixel it produces.
    function automatic pixel_t rasterize_step(input line_cmd_t c);
        pixel_t px;
        int     x0, y0, x1, y1, dx, dy, adx, ady;
        int     fx0, fy0, fx1, fy1, ddx, ddy, sx, sy;
        bit     fin;
        px = '0;
        if (c.cmd == CMD_START)
        begin
            x0 = c.xs;
            y0 = c.ys;
            x1 = c.xe;
            y1 = c.ye;
            dx = x1 - x0;
            dy = y1 - y0;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            if (adx >= ady)
            begin
                if (dx >= 0)
                    line_zone = (dy >= 0) ? ZONE_0 : ZONE_7;
                else
                    line_zone = (dy >= 0) ? ZONE_3 : ZONE_4;
            end
            else
            begin
                if (dx >= 0)
                    line_zone = (dy >= 0) ? ZONE_1 : ZONE_6;
                else
                    line_zone = (dy >= 0) ? ZONE_2 : ZONE_5;
            end
            fold_to_zone0(line_zone, x0, y0, fx0, fy0);
            fold_to_zone0(line_zone, x1, y1, fx1, fy1);
            ddx = fx1 - fx0;
            ddy = fy1 - fy0;
            pos_x = (CW+1)'(fx0);
            pos_y = (CW+1)'(fy0);
            end_x = (CW+1)'(fx1);
            inc_east = (CW+2)'(2 * ddy);
            inc_diag = (CW+2)'(2 * (ddy - ddx));
            err_term = (CW+4)'(2 * ddy - ddx);
        end
        else if (!drawing)
        begin
            // A next with no line in progress yields an all-zero beat.
            return px;
        end
        else
        begin
            if (err_term < 0)
                err_term = err_term + inc_east;
            else
            begin
                err_term = err_term + inc_diag;
                pos_y = pos_y + (CW+1)'(1);
            end
            pos_x = pos_x + (CW+1)'(1);
        end
        fin = (pos_x >= end_x);
        drawing = !fin;
        unfold_from_zone0(line_zone, pos_x, pos_y, sx, sy);
        px.x = sx[CW-1:0];
        px.y = sy[CW-1:0];
        px.valid = 1'b1;
        px.last = fin;
        return px;
    endfunction

    // Command driver: predicts each accepted beat and offers the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= CMD_START;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pixels_due_q.insert(pixels_due_q.size(), rasterize_step(cmd_on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_on_bus = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cmd_on_bus.cmd;
                    s_tdata <= {cmd_on_bus.ye, cmd_on_bus.xe, cmd_on_bus.ys, cmd_on_bus.xs};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Pixel monitor: checks each accepted beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pixels_due_q.size() == 0)
                begin
                    $error("pixel beat with no command waiting: x=%0d y=%0d",
                           $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]));
                    err_cnt++;
                end
                else
                begin
                    pixel_due = pixels_due_q.pop_front();
                    if (m_tdata[CW-1:0] !== pixel_due.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d",
                               $signed(pixel_due.x), $signed(m_tdata[CW-1:0]));
                        err_cnt++;
                    end
                    if (m_tdata[2*CW-1:CW] !== pixel_due.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d",
                               $signed(pixel_due.y), $signed(m_tdata[2*CW-1:CW]));
                        err_cnt++;
                    end
                    if (m_tuser !== pixel_due.valid)
                    begin
                        $error("pixel_valid: expected %0b, got %0b", pixel_due.valid, m_tuser);
                        err_cnt++;
                    end
                    if (m_tlast !== pixel_due.last)
                    begin
                        $error("last_pixel: expected %0b, got %0b", pixel_due.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLE)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_cmd(input cmd_t cmd, input int xs, input int ys,
                            input int xe, input int ye);
        line_cmd_t c;
        c.cmd = cmd;
        c.xs = xs[CW-1:0];
        c.ys = ys[CW-1:0];
        c.xe = xe[CW-1:0];
        c.ye = ye[CW-1:0];
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // Random coordinate, pinned to a rail now and then.
    function automatic int pick_coord();
        int sel;
        int v;
        sel = $urandom_range(19);
        v = $signed(CW'($urandom));
        if (sel == 0)
            v = CMIN;
        else if (sel == 1)
            v = CMAX;
        return v;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    // Queue random lines until at least n commands have been added.
    task automatic add_random_lines(input int n);
        int added;
        int kind, x0, y0, x1, y1, len, steps, k;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(99);
            if (kind < 5)
            begin
                // Stray next: may fall on an idle block.
                push_cmd(CMD_NEXT, pick_coord(), pick_coord(), pick_coord(), pick_coord());
                added++;
                continue;
            end
            x0 = pick_coord();
            y0 = pick_coord();
            if (kind < 10)
            begin
                x1 = x0;
                y1 = y0;
            end
            else if (kind < 85)
            begin
                x1 = clamp_coord(x0 + $urandom_range(24) - 12);
                y1 = clamp_coord(y0 + $urandom_range(24) - 12);
            end
            else
            begin
                x1 = pick_coord();
                y1 = pick_coord();
            end
            len = (x1 > x0) ? x1 - x0 : x0 - x1;
            if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
                len = (y1 > y0) ? y1 - y0 : y0 - y1;
            // Mostly run short lines to the end; long ones are cut by the next start.
            k = $urandom_range(9);
            if (len > 30)
                steps = $urandom_range(6);
            else if (k < 7)
                steps = len;
            else if (k < 9)
                steps = len + $urandom_range(1, 2);
            else
                steps = (len > 0) ? $urandom_range(len - 1) : 0;
            push_cmd(CMD_START, x0, y0, x1, y1);
            added++;
            repeat (steps)
            begin
                push_cmd(CMD_NEXT, pick_coord(), pick_coord(), pick_coord(), pick_coord());
                added++;
            end
        end
    endtask

    // Hold off until every queued command has gone and every pixel is back.
    // Sampled on the falling edge so that the handshake state has settled.
    task automatic wait_drained();
        while (cmd_q.size() > 0 || s_tvalid || pixels_due_q.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int zdx[8];
        int zdy[8];
        zdx = '{3, 1, -1, -3, -3, -1, 1, 3};
        zdy = '{1, 3, 3, 1, -1, -3, -3, -1};
        drawing = 1'b0;
        line_zone = ZONE_0;
        pos_x = '0;
        pos_y = '0;
        end_x = '0;
        err_term = '0;
        inc_east = '0;
        inc_diag = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the first idling mix.
        send_idle_pct = 22;
        recv_idle_pct = 76;
        push_cmd(CMD_NEXT, 0, 0, 0, 0);
        push_cmd(CMD_START, 0, 0, 0, 0);
        for (int i = 0; i < 8; i++)
        begin
            push_cmd(CMD_START, 100, -100, 100 + zdx[i], -100 + zdy[i]);
            push_cmd(CMD_NEXT, -1, -1, -1, -1);
        end
        push_cmd(CMD_START, CMIN, CMIN, CMAX, CMAX);
        push_cmd(CMD_NEXT, 0, 0, 0, 0);
        push_cmd(CMD_START, CMAX, CMIN, CMAX, CMIN);
        push_cmd(CMD_NEXT, 0, 0, 0, 0);
        push_cmd(CMD_START, CMIN, CMAX, CMIN + 2, CMAX);
        push_cmd(CMD_NEXT, 0, 0, 0, 0);
        push_cmd(CMD_NEXT, 0, 0, 0, 0);
        push_cmd(CMD_NEXT, 0, 0, 0, 0);
        add_random_lines(460);
        wait_drained();

        // Mostly idle sender, mostly ready receiver.
        send_idle_pct = 76;
        recv_idle_pct = 22;
        add_random_lines(470);
        wait_drained();

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_lines(470);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_cnt == 0 && pixels_due_q.size() == 0 && cmd_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> eight_zone_line_rasterizer.f
+incdir+src
src/ezlr_pkg.sv
src/ezlr_setup.sv
src/ezlr_core.sv
src/ezlr_unmap.sv
src/eight_zone_line_rasterizer.sv
tb/eight_zone_line_rasterizer_tb.sv
